// ----- src/cell_profile_slope_angle_core_defines.svh -----
// cell_profile_slope_angle_core_defines.svh
// assertion macros for the cell profile slope angle checker
// no dependencies
`ifndef CELL_PROFILE_SLOPE_ANGLE_CORE_DEFINES_SVH
`define CELL_PROFILE_SLOPE_ANGLE_CORE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define CPSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpsa same-cycle check failed");

// next-cycle implication, reset masks the check
`define CPSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpsa next-cycle check failed");

`endif

// ----- src/cpsa_pkg.sv -----
// cpsa_pkg.sv
// shared constants, types and the cordic angle table of the slope angle core
// no dependencies
package cpsa_pkg;

  localparam int MAX_CELL_SIDE = 1024;
  localparam int CORDIC_STEPS  = 16;
  localparam int TABLE_LEN     = 24;
  localparam int CORDIC_N      = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int CNT_W         = $clog2(MAX_CELL_SIDE + 1);
  localparam int CI_W          = $clog2(CORDIC_N + 1);
  localparam int K_W           = CNT_W + 16;
  localparam int HALF_PI_Q13   = 12868;

  localparam int MUL_A_W = 128;
  localparam int MUL_B_W = 64;
  localparam int MUL_P_W = 160;

  // configuration register indexes
  localparam logic CFG_AXIS       = 1'b0;
  localparam logic CFG_FULL_SCALE = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic [30:0] atan_q30(input logic [CI_W-1:0] idx);
    logic [30:0] r;
    case (int'(idx))
      0:  r = 31'd843314856;
      1:  r = 31'd497837829;
      2:  r = 31'd263043836;
      3:  r = 31'd133525158;
      4:  r = 31'd67021686;
      5:  r = 31'd33543515;
      6:  r = 31'd16775850;
      7:  r = 31'd8388437;
      8:  r = 31'd4194282;
      9:  r = 31'd2097149;
      10: r = 31'd1048575;
      11: r = 31'd524287;
      12: r = 31'd262143;
      13: r = 31'd131071;
      14: r = 31'd65535;
      15: r = 31'd32767;
      16: r = 31'd16383;
      17: r = 31'd8191;
      18: r = 31'd4095;
      19: r = 31'd2047;
      20: r = 31'd1023;
      21: r = 31'd511;
      22: r = 31'd255;
      23: r = 31'd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/cpsa_mul.sv -----
// cpsa_mul.sv
// shared shift-add multiplier, one multiplier bit per cycle, stops early
// depends on cpsa_pkg
module cpsa_mul import cpsa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a_in,
  input  logic [MUL_B_W-1:0] b_in,
  output mul_stat_t          stat,
  output logic [MUL_P_W-1:0] product
);

  logic [MUL_P_W-1:0] a_reg;
  logic [MUL_B_W-1:0] b_reg;
  logic               busy;
  logic               done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        product <= '0;
        a_reg   <= {{(MUL_P_W-MUL_A_W){1'b0}}, a_in};
        b_reg   <= b_in;
      end else if (busy) begin
        if (b_reg == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (b_reg[0]) begin
            product <= product + a_reg;
          end
          a_reg <= a_reg << 1;
          b_reg <= b_reg >> 1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- src/cell_profile_slope_angle_core.sv -----
// cell_profile_slope_angle_core.sv
// top level: least-squares profile slope of one cell, angle by cordic
// depends on cpsa_pkg and cpsa_mul
//
//   channel | signals                                   | handshake
//   --------+-------------------------------------------+-----------------------
//   in      | sample x_coord x_weight y_coord y_weight  | in_valid / in_stall
//           | end_of_row end_of_cell                    |
//   out     | angle degenerate                          | out_valid / out_stall
//   cfg     | cfg_index cfg_data                        | cfg_valid / cfg_ready
//
// each sample runs two to four products through one shift-add multiplier that
// handles one bit of its multiplier operand per cycle, up to the last significant
// one, plus a launch, a done and a retire step for each product
// the closing sample adds six more products (up to 64 bits of multiplier each),
// a one-bit-per-cycle normalize and CORDIC_STEPS steps
// rst is synchronous and clears control state, counters and sums; the config
// registers return to horizontal axis and full scale 255
// in_stall is high from an accepted request until the block is idle again; a
// held result waits in the output register while the next request is taken
module cell_profile_slope_angle_core import cpsa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        sample,
  input  logic signed [15:0] x_coord,
  input  logic [16:0]        x_weight,
  input  logic signed [15:0] y_coord,
  input  logic [16:0]        y_weight,
  input  logic               end_of_row,
  input  logic               end_of_cell,
  // result requests
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] angle,
  output logic               degenerate,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LAUNCH, ST_WAIT, ST_CLASS, ST_NORM, ST_CORDIC, ST_ROUND, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_WS, OP_WSC, OP_WC, OP_WCC, OP_K, OP_PA, OP_PB, OP_DA, OP_DB, OP_Q
  } op_t;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CELL_SIDE - 1);
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  // saturating 64-bit add
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] t;
    t = {a[63], a} + {b[63], b};
    if (t[64] != t[63]) begin
      return t[64] ? S64_MIN : S64_MAX;
    end
    return t[63:0];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] signed64(input logic [63:0] m, input logic neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  state_t state;
  op_t    op;

  // config
  logic        axis_select;
  logic [15:0] full_scale;

  // latched request
  logic [15:0]        s_l;
  logic [16:0]        w_l;
  logic [16:0]        c_mag;
  logic               c_neg;
  logic               eor_l;
  logic               eoc_l;
  logic               first_l;
  logic               vert_l;

  // cell state
  logic [CNT_W-1:0]   row_count;
  logic [CNT_W-1:0]   column_count;
  logic signed [63:0] sum_weight;
  logic signed [63:0] sum_weighted_coord;
  logic signed [63:0] sum_weighted_coord_sq;
  logic signed [63:0] sum_weighted_profile;
  logic signed [63:0] sum_weighted_profile_coord;

  // per-sample and closing intermediates
  logic [32:0]          ws;
  logic [32:0]          wc_mag;
  logic [K_W-1:0]       kq;
  logic signed [129:0]  num;
  logic signed [129:0]  den;
  logic [MUL_P_W-1:0]   p_w;
  logic [MUL_P_W-1:0]   q_w;

  // cordic
  logic signed [35:0]   cx;
  logic signed [35:0]   cy;
  logic signed [33:0]   cz;
  logic [CI_W-1:0]      ci;

  logic                 res_degen;
  logic signed [14:0]   res_angle;

  // shared multiplier
  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  mul_stat_t          mul_stat;
  logic [MUL_P_W-1:0] mul_prod;

  cpsa_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a_in    (mul_a),
    .b_in    (mul_b),
    .stat    (mul_stat),
    .product (mul_prod)
  );

  assign mul_start = (state == ST_LAUNCH);
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  logic [CNT_W-1:0] other_count;
  assign other_count = vert_l ? column_count : row_count;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_WS: begin
        mul_a = MUL_A_W'(s_l);
        mul_b = MUL_B_W'(w_l);
      end
      OP_WSC: begin
        mul_a = MUL_A_W'(ws);
        mul_b = MUL_B_W'(c_mag);
      end
      OP_WC: begin
        mul_a = MUL_A_W'(w_l);
        mul_b = MUL_B_W'(c_mag);
      end
      OP_WCC: begin
        mul_a = MUL_A_W'(wc_mag);
        mul_b = MUL_B_W'(c_mag);
      end
      OP_K: begin
        mul_a = MUL_A_W'(other_count + CNT_W'(1));
        mul_b = MUL_B_W'(full_scale);
      end
      OP_PA: begin
        mul_a = MUL_A_W'(mag64(sum_weighted_profile));
        mul_b = mag64(sum_weighted_coord);
      end
      OP_PB: begin
        mul_a = MUL_A_W'(mag64(sum_weight));
        mul_b = mag64(sum_weighted_profile_coord);
      end
      OP_DA: begin
        mul_a = MUL_A_W'(mag64(sum_weighted_coord));
        mul_b = mag64(sum_weighted_coord);
      end
      OP_DB: begin
        mul_a = MUL_A_W'(mag64(sum_weight));
        mul_b = mag64(sum_weighted_coord_sq);
      end
      OP_Q: begin
        mul_a = den[129] ? 128'(-den) : den[127:0];
        mul_b = MUL_B_W'(kq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // signed product of the two 64-bit magnitudes, as a 130-bit value
  logic               prod_neg;
  logic signed [129:0] prod_s;
  always_comb begin
    case (op)
      OP_PA:   prod_neg = sum_weighted_profile[63] ^ sum_weighted_coord[63];
      OP_PB:   prod_neg = sum_weight[63] ^ sum_weighted_profile_coord[63];
      OP_DB:   prod_neg = sum_weight[63] ^ sum_weighted_coord_sq[63];
      default: prod_neg = 1'b0;
    endcase
    prod_s = $signed({2'b00, mul_prod[127:0]});
    if (prod_neg) begin
      prod_s = -prod_s;
    end
  end

  // cordic step and final rounding
  logic signed [35:0] dx;
  logic signed [35:0] dy;
  logic signed [33:0] step_ang;
  logic signed [33:0] z_pos;
  logic [16:0]        z_round;
  logic [14:0]        z_clamp;
  always_comb begin
    dx       = cx >>> ci;
    dy       = cy >>> ci;
    step_ang = $signed({3'b000, atan_q30(ci)});
    z_pos    = cz[33] ? '0 : cz;
    z_round  = 17'((z_pos + 34'sd65536) >>> 17);
    z_clamp  = (z_round > 17'(HALF_PI_Q13)) ? 15'(HALF_PI_Q13) : z_round[14:0];
  end

  logic [MUL_P_W-1:0] pq_or;
  assign pq_or = p_w | q_w;

  logic [127:0] num_mag;
  assign num_mag = num[129] ? 128'(-num) : num[127:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state                      <= ST_IDLE;
      op                         <= OP_WS;
      axis_select                <= 1'b0;
      full_scale                 <= 16'd255;
      out_valid                  <= 1'b0;
      row_count                  <= '0;
      column_count               <= '0;
      sum_weight                 <= '0;
      sum_weighted_coord         <= '0;
      sum_weighted_coord_sq      <= '0;
      sum_weighted_profile       <= '0;
      sum_weighted_profile_coord <= '0;
    end else begin
      // config writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_AXIS:       axis_select <= cfg_data[0];
          CFG_FULL_SCALE: full_scale  <= cfg_data;
          default:        ;
        endcase
      end

      // result taken downstream, unless a new one is loaded below
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            s_l     <= sample;
            vert_l  <= axis_select;
            w_l     <= axis_select ? y_weight : x_weight;
            c_neg   <= axis_select ? y_coord[15] : x_coord[15];
            c_mag   <= axis_select ? 17'(y_coord[15] ? -{y_coord[15], y_coord} :
                                                        {y_coord[15], y_coord})
                                   : 17'(x_coord[15] ? -{x_coord[15], x_coord} :
                                                        {x_coord[15], x_coord});
            first_l <= axis_select ? (column_count == '0) : (row_count == '0);
            eor_l   <= end_of_row;
            eoc_l   <= end_of_cell;
            op      <= OP_WS;
            state   <= ST_LAUNCH;
          end
        end

        ST_LAUNCH: begin
          state <= ST_WAIT;
        end

        ST_WAIT: begin
          if (mul_stat.done) begin
            state <= ST_LAUNCH;
            case (op)
              OP_WS: begin
                ws                   <= mul_prod[32:0];
                sum_weighted_profile <= sat_add(sum_weighted_profile,
                                                signed64(64'(mul_prod[32:0]), 1'b0));
                op                   <= OP_WSC;
              end
              OP_WSC: begin
                sum_weighted_profile_coord <= sat_add(sum_weighted_profile_coord,
                                                      signed64(64'(mul_prod[48:0]), c_neg));
                if (first_l) begin
                  sum_weight <= sat_add(sum_weight, signed64(64'(w_l), 1'b0));
                  op         <= OP_WC;
                end else if (eoc_l) begin
                  op <= OP_K;
                end else begin
                  state <= ST_IDLE;
                end
              end
              OP_WC: begin
                wc_mag             <= mul_prod[32:0];
                sum_weighted_coord <= sat_add(sum_weighted_coord,
                                              signed64(64'(mul_prod[32:0]), c_neg));
                op                 <= OP_WCC;
              end
              OP_WCC: begin
                sum_weighted_coord_sq <= sat_add(sum_weighted_coord_sq,
                                                 signed64(64'(mul_prod[48:0]), 1'b0));
                if (eoc_l) begin
                  op <= OP_K;
                end else begin
                  state <= ST_IDLE;
                end
              end
              OP_K: begin
                kq <= mul_prod[K_W-1:0];
                op <= OP_PA;
              end
              OP_PA: begin
                num <= prod_s;
                op  <= OP_PB;
              end
              OP_PB: begin
                num <= num - prod_s;
                op  <= OP_DA;
              end
              OP_DA: begin
                den <= prod_s;
                op  <= OP_DB;
              end
              OP_DB: begin
                den <= den - prod_s;
                op  <= OP_Q;
              end
              OP_Q: begin
                q_w   <= mul_prod;
                p_w   <= {24'b0, num_mag, 8'b0};
                state <= ST_CLASS;
              end
              default: state <= ST_IDLE;
            endcase

            // row and column bookkeeping for a sample that does not close the cell
            if (!eoc_l && ((op == OP_WSC && !first_l) || op == OP_WCC)) begin
              if (eor_l) begin
                column_count <= '0;
                if (row_count < CNT_LAST) begin
                  row_count <= row_count + CNT_W'(1);
                end
              end else if (column_count < CNT_LAST) begin
                column_count <= column_count + CNT_W'(1);
              end
            end
          end
        end

        ST_CLASS: begin
          res_degen <= 1'b0;
          res_angle <= '0;
          if (p_w == '0 && q_w == '0) begin
            res_degen <= 1'b1;
            state     <= ST_DONE;
          end else if (q_w == '0) begin
            res_angle <= num[129] ? -15'sd12868 : 15'sd12868;
            state     <= ST_DONE;
          end else if (p_w == '0) begin
            state <= ST_DONE;
          end else begin
            state <= ST_NORM;
          end
        end

        // bring the larger operand to exactly 32 significant bits
        ST_NORM: begin
          if (pq_or[MUL_P_W-1:32] != '0) begin
            p_w <= p_w >> 1;
            q_w <= q_w >> 1;
          end else if (!pq_or[31]) begin
            p_w <= p_w << 1;
            q_w <= q_w << 1;
          end else begin
            cx    <= $signed({4'b0, q_w[31:0]});
            cy    <= $signed({4'b0, p_w[31:0]});
            cz    <= '0;
            ci    <= '0;
            state <= ST_CORDIC;
          end
        end

        ST_CORDIC: begin
          if (ci == CI_W'(CORDIC_N)) begin
            state <= ST_ROUND;
          end else begin
            if (!cy[35]) begin
              cx <= cx + dy;
              cy <= cy - dx;
              cz <= cz + step_ang;
            end else begin
              cx <= cx - dy;
              cy <= cy + dx;
              cz <= cz - step_ang;
            end
            ci <= ci + CI_W'(1);
          end
        end

        ST_ROUND: begin
          res_angle <= (num[129] != den[129]) ? -$signed(z_clamp) : $signed(z_clamp);
          state     <= ST_DONE;
        end

        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid                  <= 1'b1;
            angle                      <= res_angle;
            degenerate                 <= res_degen;
            row_count                  <= '0;
            column_count               <= '0;
            sum_weight                 <= '0;
            sum_weighted_coord         <= '0;
            sum_weighted_coord_sq      <= '0;
            sum_weighted_profile       <= '0;
            sum_weighted_profile_coord <= '0;
            state                      <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/cpsa_checker.sv -----
// cpsa_checker.sv
// port-level checks of the slope angle core, bound to the top level
// depends on cell_profile_slope_angle_core_defines.svh
`include "cell_profile_slope_angle_core_defines.svh"

module cpsa_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [14:0] angle,
  input logic               degenerate
);

  // a taken request keeps the block busy in the cycle after it
  `CPSA_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)

  // a new result comes with the block already free for the next request
  `CPSA_ASSERT_NOW(a_free_on_result, $rose(out_valid), !in_stall)

  // degenerate results carry a zero angle, all angles stay within half pi
  `CPSA_ASSERT_NOW(a_degen_zero, out_valid && degenerate, angle == 15'sd0)
  `CPSA_ASSERT_NOW(a_angle_range, out_valid, angle <= 15'sd12868 && angle >= -15'sd12868)

  // a held result does not change
  `CPSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(angle) && $stable(degenerate))

endmodule

bind cell_profile_slope_angle_core cpsa_checker u_cpsa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .angle      (angle),
  .degenerate (degenerate)
);

// ----- test/tb_cell_profile_slope_angle_core.sv -----
// tb_cell_profile_slope_angle_core.sv
// self-checking bench for the cell profile slope angle core: directed table, random cells
// depends on cpsa_pkg and the core rtl
module tb_cell_profile_slope_angle_core;
  import cpsa_pkg::*;

  // one input request as it crosses the in channel
  typedef struct packed {
    logic [15:0]        smp;
    logic signed [15:0] xc;
    logic [16:0]        xw;
    logic signed [15:0] yc;
    logic [16:0]        yw;
    logic               eor;
    logic               eoc;
  } cell_req_t;

  typedef struct packed {
    logic signed [14:0] ang;
    logic               dg;
  } slope_res_t;

  // directed row: typed marks rows whose result is written in by hand
  typedef struct packed {
    cell_req_t          rq;
    logic               typed;
    logic signed [14:0] ang;
    logic               dg;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [15:0]        sample;
  logic signed [15:0] x_coord;
  logic [16:0]        x_weight;
  logic signed [15:0] y_coord;
  logic [16:0]        y_weight;
  logic               end_of_row;
  logic               end_of_cell;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [14:0] angle;
  logic               degenerate;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [15:0]        cfg_data;

  always #5 clk = ~clk;

  cell_profile_slope_angle_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample(sample), .x_coord(x_coord), .x_weight(x_weight),
    .y_coord(y_coord), .y_weight(y_weight),
    .end_of_row(end_of_row), .end_of_cell(end_of_cell),
    .out_valid(out_valid), .out_stall(out_stall),
    .angle(angle), .degenerate(degenerate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // floor(atan(2^-i) * 2^30), own copy for the predictor
  localparam longint ATAN_Q30 [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  // predictor copy of config and cell state
  logic               pr_axis;
  logic [15:0]        pr_fs;
  int                 pr_rows;
  int                 pr_cols;
  logic signed [63:0] pr_sw, pr_swc, pr_swcc, pr_sp, pr_spc;

  slope_res_t slope_q[$];      // angles still owed by the block
  dir_row_t   dir_tab[$];
  int         n_err = 0;
  int         n_sent = 0;
  int         snd_idle_pct = 0;
  int         rcv_idle_pct = 0;
  logic       hold_req = 1'b0;
  int         hold_left = 0;

  task automatic flag_mismatch(input string what);
    n_err++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] t;
    t = {a[63], a} + {b[63], b};
    if (t[64] != t[63]) return t[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return t[63:0];
  endfunction

  // signed product wrapped to 128 bits
  function automatic logic [127:0] wide_mul(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
    logic signed [127:0] ea, eb;
    ea = a;
    eb = b;
    return ea * eb;
  endfunction

  function automatic int msb_len(input logic [191:0] v);
    for (int i = 191; i >= 0; i--) if (v[i]) return i + 1;
    return 0;
  endfunction

  function automatic logic [31:0] lead32(input logic [191:0] v, input int len);
    if (len >= 32) return 32'(v >> (len - 32));
    return 32'(v << (32 - len));
  endfunction

  // vectoring rotations from (q, p) down to the x axis, angle in Q2.13
  function automatic logic signed [14:0] rotate_angle(input logic [31:0] q,
                                                      input logic [31:0] p);
    logic signed [63:0] x, y, z, dx, dy;
    x = {32'd0, q};
    y = {32'd0, p};
    z = 0;
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x = x + dy; y = y - dx; z = z + ATAN_Q30[i];
      end else begin
        x = x - dy; y = y + dx; z = z - ATAN_Q30[i];
      end
    end
    if (z < 0) z = 0;
    z = (z + 65536) >>> 17;
    if (z > HALF_PI_Q13) z = HALF_PI_Q13;
    return 15'(z);
  endfunction

  function automatic void clear_cell();
    pr_rows = 0; pr_cols = 0;
    pr_sw = 0; pr_swc = 0; pr_swcc = 0; pr_sp = 0; pr_spc = 0;
  endfunction

  // fold one accepted request into the sums, queue an angle on the closing one
  function automatic void fold_request(input cell_req_t r, input logic typed,
                                       input logic signed [14:0] t_ang, input logic t_dg);
    logic signed [63:0] s, c, w, ws;
    logic               vert, first, nneg, dneg;
    logic [127:0]       pa, pb, d, nm, dn;
    logic [191:0]       pw, qw;
    logic [63:0]        kq;
    int                 lp, lq, ln;
    slope_res_t         e;
    vert  = pr_axis;
    s     = {48'd0, r.smp};
    c     = vert ? {{48{r.yc[15]}}, r.yc} : {{48{r.xc[15]}}, r.xc};
    w     = {47'd0, vert ? r.yw : r.xw};
    first = vert ? (pr_cols == 0) : (pr_rows == 0);
    ws    = w * s;
    pr_sp  = sat_sum(pr_sp, ws);
    pr_spc = sat_sum(pr_spc, ws * c);
    if (first) begin
      pr_sw   = sat_sum(pr_sw, w);
      pr_swc  = sat_sum(pr_swc, w * c);
      pr_swcc = sat_sum(pr_swcc, w * c * c);
    end
    if (!r.eoc) begin
      if (r.eor) begin
        pr_cols = 0;
        if (pr_rows < MAX_CELL_SIDE - 1) pr_rows++;
      end else if (pr_cols < MAX_CELL_SIDE - 1) begin
        pr_cols++;
      end
      return;
    end
    // closing request: normal equations, then the angle
    kq   = 64'((vert ? pr_cols : pr_rows) + 1) * 64'(pr_fs);
    pa   = wide_mul(pr_sp, pr_swc);
    pb   = wide_mul(pr_sw, pr_spc);
    d    = pa - pb;
    nneg = d[127];
    nm   = nneg ? -d : d;
    pa   = wide_mul(pr_swc, pr_swc);
    pb   = wide_mul(pr_sw, pr_swcc);
    d    = pa - pb;
    dneg = d[127];
    dn   = dneg ? -d : d;
    pw   = {56'd0, nm, 8'd0};
    qw   = 192'(dn) * 192'(kq);
    lp   = msb_len(pw);
    lq   = msb_len(qw);
    e.ang = '0;
    e.dg  = 1'b0;
    if (lp == 0 && lq == 0) begin
      e.dg = 1'b1;
    end else if (lq == 0) begin
      e.ang = nneg ? -15'(HALF_PI_Q13) : 15'(HALF_PI_Q13);
    end else if (lp != 0) begin
      ln = (lp > lq) ? lp : lq;
      e.ang = rotate_angle(lead32(qw, ln), lead32(pw, ln));
      if (nneg != dneg) e.ang = -e.ang;
    end
    if (typed) begin
      e.ang = t_ang;
      e.dg  = t_dg;
    end
    slope_q.push_back(e);
    clear_cell();
  endfunction

  // offer one request, with random sender gaps, and wait for it to be taken
  task automatic offer(input cell_req_t r, input logic typed = 1'b0,
                       input logic signed [14:0] t_ang = '0, input logic t_dg = 1'b0);
    if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid    <= 1'b1;
    sample      <= r.smp;
    x_coord     <= r.xc;
    x_weight    <= r.xw;
    y_coord     <= r.yc;
    y_weight    <= r.yw;
    end_of_row  <= r.eor;
    end_of_cell <= r.eoc;
    do @(posedge clk); while (in_stall);
    fold_request(r, typed, t_ang, t_dg);
    n_sent++;
  endtask

  function automatic logic [16:0] pick_weight();
    int k;
    k = $urandom_range(99);
    if (k < 25) return 17'd65536;
    if (k < 32) return 17'd0;
    if (k < 37) return 17'h1FFFF;
    return 17'($urandom_range(0, 131071));
  endfunction

  function automatic logic [15:0] pick_sample();
    int k;
    k = $urandom_range(99);
    if (k < 10) return 16'd0;
    if (k < 15) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // well-formed cell on a regular grid; open cells stop before the closing request
  task automatic rand_cell(input int nr, input int nc, input logic closed);
    cell_req_t          r;
    logic signed [15:0] x0, y0, dx, dy;
    logic [16:0]        xw [16];
    logic [16:0]        yw;
    logic               drop_eor;
    x0 = 16'($urandom);
    y0 = 16'($urandom);
    dx = 16'($urandom_range(0, 1024)) - 16'sd512;
    dy = 16'($urandom_range(0, 1024)) - 16'sd512;
    drop_eor = ($urandom_range(99) < 30);
    for (int j = 0; j < nc; j++) xw[j] = pick_weight();
    for (int i = 0; i < nr; i++) begin
      yw = pick_weight();
      for (int j = 0; j < nc; j++) begin
        r.smp = pick_sample();
        r.xc  = x0 + 16'(j) * dx;
        r.xw  = xw[j];
        r.yc  = y0 + 16'(i) * dy;
        r.yw  = yw;
        r.eoc = closed && i == nr - 1 && j == nc - 1;
        r.eor = (j == nc - 1) && !(r.eoc && drop_eor);
        offer(r);
      end
    end
  endtask

  task automatic noise_req();
    cell_req_t r;
    r = cell_req_t'({$urandom, $urandom, $urandom});
    r.eor = ($urandom_range(99) < 30);
    r.eoc = ($urandom_range(99) < 5);
    offer(r);
  endtask

  // mostly small regular cells, some larger ones, some broken streams
  task automatic rand_phase(input int upto);
    int k;
    while (n_sent < upto) begin
      k = $urandom_range(99);
      if (k < 10) noise_req();
      else if (k < 14) rand_cell($urandom_range(1, 12), $urandom_range(1, 12), 1'b1);
      else rand_cell($urandom_range(1, 4), $urandom_range(1, 5), 1'b1);
    end
  endtask

  // stop offering until every owed angle is out
  task automatic drain();
    in_valid <= 1'b0;
    wait (slope_q.size() == 0);
    @(posedge clk);
  endtask

  // both registers, written only while the block is idle
  task automatic set_regs(input logic ax, input logic [15:0] fs);
    drain();
    // requests that close no cell may still be in flight
    repeat (600) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_AXIS;
    cfg_data  <= {15'd0, ax};
    do @(posedge clk); while (!cfg_ready);
    pr_axis = ax;
    cfg_index <= CFG_FULL_SCALE;
    cfg_data  <= fs;
    do @(posedge clk); while (!cfg_ready);
    pr_fs = fs;
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_row(input logic [15:0] s, input logic signed [15:0] xc,
                                  input logic [16:0] xw, input logic signed [15:0] yc,
                                  input logic [16:0] yw, input logic eor, input logic eoc,
                                  input logic typed = 1'b0,
                                  input logic signed [14:0] ang = '0, input logic dg = 1'b0);
    dir_row_t d;
    d.rq    = '{smp: s, xc: xc, xw: xw, yc: yc, yw: yw, eor: eor, eoc: eoc};
    d.typed = typed;
    d.ang   = ang;
    d.dg    = dg;
    dir_tab.push_back(d);
  endfunction

  // result side: check taken results, random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (slope_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result angle %0d", angle));
        end else begin
          slope_res_t e;
          e = slope_q.pop_front();
          if (angle !== e.ang)
            flag_mismatch($sformatf("angle %0d, want %0d", angle, e.ang));
          if (degenerate !== e.dg)
            flag_mismatch($sformatf("degenerate %b, want %b", degenerate, e.dg));
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    cell_req_t r;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    sample      <= '0;
    x_coord     <= '0;
    x_weight    <= '0;
    y_coord     <= '0;
    y_weight    <= '0;
    end_of_row  <= 1'b0;
    end_of_cell <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_AXIS;
    cfg_data    <= '0;
    pr_axis = 1'b0;
    pr_fs   = 16'd255;
    clear_cell();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset config: horizontal, full scale 255
    // single-request cells always come out degenerate
    add_row(16'd0, 16'sd0, 17'd0, 16'sd0, 17'd0, 1, 1, 1, 15'sd0, 1);
    add_row(16'hFFFF, -16'sd32768, 17'd65536, 16'sd32767, 17'h1FFFF, 1, 1, 1, 15'sd0, 1);
    // flat profile over two columns: zero numerator only
    add_row(16'd1000, -16'sd256, 17'd65536, 16'sd0, 17'd65536, 0, 0);
    add_row(16'd1000, 16'sd256, 17'd65536, 16'sd0, 17'd65536, 1, 1, 1, 15'sd0, 0);
    // one-column first row gives a zero denominator: plus and minus pi/2
    add_row(16'd0, 16'sd256, 17'd65536, 16'sd0, 17'd65536, 1, 0);
    add_row(16'd100, 16'sd0, 17'd65536, 16'sd256, 17'd65536, 1, 1, 1, 15'sd12868, 0);
    add_row(16'd0, 16'sd0, 17'd65536, 16'sd0, 17'd65536, 1, 0);
    add_row(16'd100, 16'sd256, 17'd65536, 16'sd256, 17'd65536, 1, 1, 1, -15'sd12868, 0);
    // 2x2 cell closed without end of row
    add_row(16'd10, -16'sd128, 17'd40000, -16'sd128, 17'd50000, 0, 0);
    add_row(16'd200, 16'sd128, 17'd60000, -16'sd128, 17'd50000, 1, 0);
    add_row(16'd30, -16'sd128, 17'd40000, 16'sd128, 17'd30000, 0, 0);
    add_row(16'd250, 16'sd128, 17'd60000, 16'sd128, 17'd30000, 0, 1);
    // extremes: full weights above one, coordinate and sample limits
    add_row(16'hFFFF, -16'sd32768, 17'h1FFFF, 16'sd32767, 17'h1FFFF, 0, 0);
    add_row(16'd0, 16'sd32767, 17'h1FFFF, -16'sd32768, 17'h1FFFF, 0, 0);
    add_row(16'hFFFF, 16'sd0, 17'd0, 16'sd0, 17'd0, 1, 0);
    add_row(16'h5555, 16'sh5555, 17'h0AAAA, 16'shAAAA, 17'h15555, 0, 0);
    add_row(16'hAAAA, 16'shAAAA, 17'h15555, 16'sh5555, 17'h0AAAA, 1, 1);
    // broken stream: bare rows, then a stray close
    add_row(16'd7, 16'sd1, 17'd1, 16'sd1, 17'd1, 1, 0);
    add_row(16'd9, -16'sd1, 17'd3, 16'sd2, 17'd1, 1, 0);
    add_row(16'd11, 16'sd5, 17'd5, -16'sd3, 17'd1, 0, 1);
    snd_idle_pct = 30;
    rcv_idle_pct = 54;
    foreach (dir_tab[i]) offer(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].ang, dir_tab[i].dg);

    // sender idles 30 percent, receiver 54
    set_regs(1'b0, 16'hFFFF);
    rand_phase(350);
    rand_cell(2, 3, 1'b0);       // left open across the axis change

    // the other way round, with one long receiver hold-off
    snd_idle_pct = 54;
    rcv_idle_pct = 30;
    set_regs(1'b1, 16'd1);
    rand_phase(450);
    hold_req = 1'b1;
    rand_phase(600);
    rand_cell(1, 4, 1'b0);

    // no idling on either side, full scale zero
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_regs(1'b0, 16'd0);
    rand_phase(700);
    drain();
    rand_phase(800);
    rand_cell(3, 2, 1'b0);

    set_regs(1'b1, 16'($urandom_range(1, 65535)));
    rand_phase(880);

    // one row longer than the column counter counts before it saturates
    for (int j = 0; j < 1030; j++) begin
      r.smp = pick_sample();
      r.xc  = 16'($urandom);
      r.xw  = pick_weight();
      r.yc  = 16'($urandom);
      r.yw  = pick_weight();
      r.eor = 1'b0;
      r.eoc = (j == 1029);
      offer(r);
    end
    rand_cell(2, 2, 1'b1);

    in_valid <= 1'b0;
    wait (slope_q.size() == 0);
    repeat (600) @(posedge clk);
    if (n_err == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/cpsa_pkg.sv
src/cpsa_mul.sv
src/cell_profile_slope_angle_core.sv
src/cpsa_checker.sv
test/tb_cell_profile_slope_angle_core.sv
